// ===== rtl/xsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// xsrd_pkg
// Types and constants shared by the cross-reference stream row decoder.
// ----------------------------------------------------------------------------
package xsrd_pkg;

  // Input beat kinds
  localparam logic REQ_SUBSECTION = 1'b0;
  localparam logic REQ_DATA       = 1'b1;

  // Entry kinds
  localparam logic [1:0] KIND_FREE       = 2'd0;
  localparam logic [1:0] KIND_USED       = 2'd1;
  localparam logic [1:0] KIND_COMPRESSED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TYPE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SECOND_WIDTH = 2'd1;
  localparam logic [1:0] REG_THIRD_WIDTH  = 2'd2;

  // Configuration reset values
  localparam logic [3:0] RST_TYPE_WIDTH   = 4'd1;
  localparam logic [3:0] RST_SECOND_WIDTH = 4'd2;
  localparam logic [3:0] RST_THIRD_WIDTH  = 4'd1;

  // Entries held between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        req_type;
    logic [30:0] first_number;
    logic [7:0]  data_byte;
  } xsrd_in_t;

  typedef struct packed {
    logic [1:0]  entry_type;
    logic [63:0] location;
    logic [63:0] object_id;
    logic [63:0] generation;
  } xsrd_out_t;

  // Field widths as programmed
  typedef struct packed {
    logic [3:0] type_width;
    logic [3:0] second_width;
    logic [3:0] third_width;
  } xsrd_cfg_t;

  // Finished row as handed from front to back
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] second;
    logic [63:0] third;
    logic [31:0] running;
  } xsrd_rec_t;

endpackage

// ===== rtl/xsrd_front.sv =====
// ----------------------------------------------------------------------------
// xsrd_front
// Takes input beats, gathers row bytes into the three fields and hands a
// finished row of a known type to the queue.
// ----------------------------------------------------------------------------
module xsrd_front #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xsrd_pkg::xsrd_cfg_t cfg_i,
  input  logic              accept_i,
  input  xsrd_pkg::xsrd_in_t  in_data_i,
  output logic              push_o,
  output xsrd_pkg::xsrd_rec_t rec_o
);
  import xsrd_pkg::*;

  localparam int unsigned ACC_W = 8 * MAX_FIELD_BYTES;
  localparam int unsigned POS_W = $clog2(3 * MAX_FIELD_BYTES + 1);

  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [ACC_W-1:0] type_acc_q, type_acc_d;
  logic [ACC_W-1:0] sec_acc_q, sec_acc_d;
  logic [ACC_W-1:0] thd_acc_q, thd_acc_d;
  logic [31:0]      next_obj_q, next_obj_d;
  logic [3:0]       w0, w1, w2;
  logic [POS_W-1:0] len, bound0, bound1;
  logic [ACC_W-1:0] byte_ext;

  // Widths above the field limit count as the limit
  function automatic logic [3:0] clamp_width(input logic [3:0] w);
    return (w > 4'(MAX_FIELD_BYTES)) ? 4'(MAX_FIELD_BYTES) : w;
  endfunction

  assign w0       = clamp_width(cfg_i.type_width);
  assign w1       = clamp_width(cfg_i.second_width);
  assign w2       = clamp_width(cfg_i.third_width);
  assign bound0   = POS_W'(w0);
  assign bound1   = POS_W'(w0) + POS_W'(w1);
  assign len      = bound1 + POS_W'(w2);
  assign pos_inc  = pos_q + POS_W'(1);
  assign byte_ext = ACC_W'(in_data_i.data_byte);

  // Row gathering and end-of-row detection
  always_comb begin
    pos_d      = pos_q;
    type_acc_d = type_acc_q;
    sec_acc_d  = sec_acc_q;
    thd_acc_d  = thd_acc_q;
    next_obj_d = next_obj_q;
    push_o     = 1'b0;
    rec_o.kind    = (w0 == 4'd0) ? KIND_USED : type_acc_d[1:0];
    rec_o.second  = 64'(sec_acc_d);
    rec_o.third   = 64'(thd_acc_d);
    rec_o.running = next_obj_q;
    if (accept_i) begin
      if (in_data_i.req_type == REQ_SUBSECTION) begin
        pos_d      = '0;
        type_acc_d = '0;
        sec_acc_d  = '0;
        thd_acc_d  = '0;
        next_obj_d = {1'b0, in_data_i.first_number};
      end else if (len != '0) begin
        priority if (pos_q < bound0) begin
          type_acc_d = (type_acc_q << 8) | byte_ext;
        end else if (pos_q < bound1) begin
          sec_acc_d = (sec_acc_q << 8) | byte_ext;
        end else begin
          thd_acc_d = (thd_acc_q << 8) | byte_ext;
        end
        pos_d = pos_inc;
        if (pos_inc >= len) begin
          // Row complete: emit known types, always advance the object number
          rec_o.kind   = (w0 == 4'd0) ? KIND_USED : type_acc_d[1:0];
          rec_o.second = 64'(sec_acc_d);
          rec_o.third  = 64'(thd_acc_d);
          push_o       = (w0 == 4'd0) || (type_acc_d < ACC_W'(3));
          next_obj_d   = next_obj_q + 32'd1;
          pos_d        = '0;
          type_acc_d   = '0;
          sec_acc_d    = '0;
          thd_acc_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      type_acc_q <= '0;
      sec_acc_q  <= '0;
      thd_acc_q  <= '0;
      next_obj_q <= '0;
    end else begin
      pos_q      <= pos_d;
      type_acc_q <= type_acc_d;
      sec_acc_q  <= sec_acc_d;
      thd_acc_q  <= thd_acc_d;
      next_obj_q <= next_obj_d;
    end
  end

endmodule

// ===== rtl/xsrd_queue.sv =====
// ----------------------------------------------------------------------------
// xsrd_queue
// Short register queue of finished rows between front and back.
// ----------------------------------------------------------------------------
module xsrd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xsrd_pkg::xsrd_rec_t rec_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output xsrd_pkg::xsrd_rec_t rec_o
);
  import xsrd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  xsrd_rec_t        slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

// ===== rtl/xsrd_back.sv =====
// ----------------------------------------------------------------------------
// xsrd_back
// Maps a queued row onto the output fields and holds it in the output
// register until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module xsrd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rec_valid_i,
  input  xsrd_pkg::xsrd_rec_t rec_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xsrd_pkg::xsrd_out_t out_data_o
);
  import xsrd_pkg::*;

  logic      out_valid_q, out_valid_d;
  xsrd_out_t out_q, out_d;

  assign pop_o = rec_valid_i && (!out_valid_q || out_ready_i);

  // Field mapping per entry kind
  always_comb begin
    out_d.entry_type = rec_i.kind;
    if (rec_i.kind == KIND_COMPRESSED) begin
      out_d.location   = rec_i.third;
      out_d.object_id  = rec_i.second;
      out_d.generation = 64'(rec_i.running);
    end else begin
      out_d.location   = rec_i.second;
      out_d.object_id  = 64'(rec_i.running);
      out_d.generation = rec_i.third;
    end
    out_valid_d = pop_o || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/xref_stream_row_decoder.sv =====
// ----------------------------------------------------------------------------
// xref_stream_row_decoder
// Decodes the rows of a cross-reference stream into object entries.
//
//   Port group   Direction  Handshake          Beat
//   in_*         in         valid / ready      subsection start or data byte
//   out_*        out        valid / ready      one decoded entry
//   APB          in         psel/penable       field width registers
//
// One input beat per cycle. The front takes a beat whenever the row queue
// has space; the edge that takes the last byte of a row of known type writes
// it into a queue slot, and the back moves it on into the output register
// that drives out_valid_o. Downstream stalls fill the two-entry queue and the
// output register before in_ready_o drops.
// Reset clears the row state, the object counter and the queue, and sets
// the widths to 1, 2 and 1 bytes.
// ----------------------------------------------------------------------------
module xref_stream_row_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xsrd_pkg::xsrd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xsrd_pkg::xsrd_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import xsrd_pkg::*;

  xsrd_cfg_t cfg_q, cfg_d;
  logic      cfg_wr;
  logic      accept, push, full, q_valid, pop;
  xsrd_rec_t front_rec, q_rec;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TYPE_WIDTH:   cfg_d.type_width   = pwdata[3:0];
        REG_SECOND_WIDTH: cfg_d.second_width = pwdata[3:0];
        REG_THIRD_WIDTH:  cfg_d.third_width  = pwdata[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TYPE_WIDTH:   prdata = {28'd0, cfg_q.type_width};
      REG_SECOND_WIDTH: prdata = {28'd0, cfg_q.second_width};
      REG_THIRD_WIDTH:  prdata = {28'd0, cfg_q.third_width};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_width   <= RST_TYPE_WIDTH;
      cfg_q.second_width <= RST_SECOND_WIDTH;
      cfg_q.third_width  <= RST_THIRD_WIDTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input side
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  xsrd_front #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .rec_o     (front_rec)
  );

  xsrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  xsrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (q_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
